/* sv/ers_pkg.sv */
// ----------------------------------------------------------------------------
// ers_pkg
// Operation codes, button codes, motor commands and sequencer state type for the
// elevator request scheduler.
// ----------------------------------------------------------------------------
package ers_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned FLOOR_W  = 4;
    localparam int unsigned BUTTON_W = 2;
    localparam int unsigned PEND_W   = 12;

    localparam logic [OP_W-1:0] OP_PRESS  = 3'd0;
    localparam logic [OP_W-1:0] OP_ARRIVE = 3'd1;
    localparam logic [OP_W-1:0] OP_SERVE  = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_CHOOSE = 3'd4;

    localparam logic [BUTTON_W-1:0] BTN_HALL_UP   = 2'd0;
    localparam logic [BUTTON_W-1:0] BTN_HALL_DOWN = 2'd1;
    localparam logic [BUTTON_W-1:0] BTN_CAB       = 2'd2;

    localparam logic [1:0] MOTOR_STOP = 2'b00;
    localparam logic [1:0] MOTOR_UP   = 2'b01;
    localparam logic [1:0] MOTOR_DOWN = 2'b11;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

endpackage

/* sv/elevator_request_scheduler.sv */
// ----------------------------------------------------------------------------
// elevator_request_scheduler
// Collective-control scheduler: request store, stop decision and direction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one event per transfer: the operation code in
//   tuser, floor and button in tdata. Master channel returns exactly one
//   result per event: stop decision, motor command and all request bits.
//   Arrive and choose-direction events walk the floors one per cycle through
//   a single floor comparator that ORs request bits into "below" and "above"
//   accumulators and captures the bits of the reference floor. The other events
//   skip the walk and go straight to the finish step; both kinds load their
//   result into the output register in that step.
//   The block takes one event at a time: o_s_tready is high only while the
//   sequencer is idle. A finished result sits in the output register; if
//   the receiver stalls, the sequencer holds in its finish step (state not
//   yet committed) until the register frees, so nothing is lost.
//   Reset (i_rst_n low, synchronous) clears all requests, marks the floor
//   unknown, sets the direction to up and the cab stationary, and drops any
//   pending result.
// ----------------------------------------------------------------------------
module elevator_request_scheduler #(
    parameter int unsigned FLOORS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // tuser: operation[2:0]
    input  logic [2:0]             i_s_tuser,
    // tdata: floor[3:0], button[5:4], zero[7:6]
    input  logic [7:0]             i_s_tdata,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // tdata: stop_here[0], motor_direction[2:1], pending_requests[14:3], zero[15]
    output logic [15:0]            o_m_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready
);
    import ers_pkg::*;

    localparam int unsigned FW  = (FLOORS > 1) ? $clog2(FLOORS) : 1;
    localparam int unsigned RW  = 3 * FLOORS;
    localparam int unsigned FLW = (RW > PEND_W) ? RW : PEND_W;
    localparam logic [FW-1:0] LAST_IDX = FW'(FLOORS - 1);

    t_state r_state, n_state;

    logic [2:0]          r_req [FLOORS];
    logic [FLOOR_W-1:0]  r_cur;
    logic                r_known;
    logic                r_up;
    logic                r_still;

    // latched event
    logic [OP_W-1:0]     r_op;
    logic [FLOOR_W-1:0]  r_floor;
    logic [BUTTON_W-1:0] r_button;
    logic [FLOOR_W-1:0]  r_ref;

    // floor walk
    logic [FW-1:0]       r_idx;
    logic                r_below;
    logic                r_above;
    logic [2:0]          r_here;

    logic                r_out_valid;
    logic [15:0]         r_out_data;

    logic                s_xfer;
    logic                fin_go;
    logic                in_range;
    logic [FLOOR_W-1:0]  idx_ext;
    logic [2:0]          scan_bits;
    logic                ahead, behind;
    logic                same_call, opp_call;
    logic                stop;
    logic                n_known, n_up, n_still;
    logic [1:0]          motor;
    logic [FLW-1:0]      flat;
    logic [RW-1:0]       req_flat;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign fin_go     = (r_state == S_FINISH) && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign in_range  = {1'b0, r_floor} < (FLOOR_W + 1)'(FLOORS);
    assign idx_ext   = FLOOR_W'(r_idx);
    assign scan_bits = r_req[r_idx];

    // Sequencer: scan only the operations that need the neighbor floors.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    if (i_s_tuser == OP_ARRIVE || i_s_tuser == OP_CHOOSE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Stop decision and direction choice from the walk results.
    always_comb begin
        ahead     = r_up ? r_above : r_below;
        behind    = r_up ? r_below : r_above;
        same_call = r_up ? r_here[0] : r_here[1];
        opp_call  = r_up ? r_here[1] : r_here[0];
        stop      = 1'b0;
        n_known   = r_known;
        n_up      = r_up;
        n_still   = r_still;
        case (r_op)
            OP_ARRIVE: begin
                n_known = in_range;
                if (in_range) begin
                    stop = same_call || r_here[2] || (!ahead && opp_call);
                end
            end
            OP_CHOOSE: begin
                if (r_known) begin
                    if (ahead) begin
                        n_still = 1'b0;
                    end else if (behind) begin
                        n_still = 1'b0;
                        n_up    = !r_up;
                    end else begin
                        n_still = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        motor = n_still ? MOTOR_STOP : (n_up ? MOTOR_UP : MOTOR_DOWN);
    end

    // Request bits after this event, flattened for the result word.
    always_comb begin
        for (int f = 0; f < FLOORS; f++) begin
            req_flat[3*f +: 3] = r_req[f];
            case (r_op)
                OP_PRESS: begin
                    if (in_range && r_button <= BTN_CAB && r_floor[FW-1:0] == FW'(f)) begin
                        req_flat[3*f + 32'(r_button)] = 1'b1;
                    end
                end
                OP_SERVE: begin
                    if (r_known && r_cur[FW-1:0] == FW'(f)) begin
                        req_flat[3*f +: 3] = 3'b000;
                    end
                end
                OP_CLEAR: req_flat[3*f +: 3] = 3'b000;
                default: ;
            endcase
        end
        flat = FLW'(req_flat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_known     <= 1'b0;
            r_up        <= 1'b1;
            r_still     <= 1'b1;
            r_out_valid <= 1'b0;
            for (int f = 0; f < FLOORS; f++) begin
                r_req[f] <= 3'b000;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= fin_go || (r_out_valid && !i_m_tready);
            // commit state and load the result in one step
            if (fin_go) begin
                r_known     <= n_known;
                r_up        <= n_up;
                r_still     <= n_still;
                if (r_op == OP_ARRIVE && in_range) begin
                    r_cur <= r_floor;
                end
                for (int f = 0; f < FLOORS; f++) begin
                    r_req[f] <= req_flat[3*f +: 3];
                end
            end
        end
    end

    // Payload: event latch, floor walk and result word.
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_op     <= i_s_tuser;
            r_floor  <= i_s_tdata[3:0];
            r_button <= i_s_tdata[5:4];
            r_ref    <= (i_s_tuser == OP_ARRIVE) ? i_s_tdata[3:0] : r_cur;
            r_idx    <= '0;
            r_below  <= 1'b0;
            r_above  <= 1'b0;
            r_here   <= 3'b000;
        end else if (r_state == S_SCAN) begin
            if (idx_ext < r_ref) begin
                r_below <= r_below || (scan_bits != 3'b000);
            end else if (idx_ext > r_ref) begin
                r_above <= r_above || (scan_bits != 3'b000);
            end else begin
                r_here <= scan_bits;
            end
            r_idx <= r_idx + 1'b1;
        end
        if (fin_go) begin
            r_out_data <= {1'b0, flat[PEND_W-1:0], motor, stop};
        end
    end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for elevator_request_scheduler. Directed tests cover
// the unknown-floor case, press range limits, every stop decision path and
// the undefined operations; a random sweep then walks the cab floor to floor
// on random calls. A scoreboard predicts each result and compares it with
// every result the block returns.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ers_pkg::*;

    localparam int unsigned FLOORS      = 4;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_TAIL  = FLOORS + 4;
    localparam int unsigned MAX_REPORTS = 30;

    // operation codes the block must ignore
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;
    // button code that names no button
    localparam logic [BUTTON_W-1:0] BTN_NONE = 2'd3;

    // result layout, lowest bit first: stop, motor, pending requests, pad
    typedef struct packed {
        logic              pad;
        logic [PEND_W-1:0] pending;
        logic [1:0]        motor;
        logic              stop;
    } outcome_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic [2:0]  i_s_tuser;    // operation[2:0]
    logic [7:0]  i_s_tdata;    // floor[3:0], button[5:4], zero[7:6]
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] o_m_tdata;    // stop[0], motor[2:1], pending[14:3], zero[15]
    logic        o_m_tvalid;
    logic        i_m_tready;

    // scheduler state as the bench sees it
    logic [PEND_W-1:0] req_bits;
    logic [3:0]        at_floor;
    logic              floor_valid;
    logic              heading_up;
    logic              parked;

    outcome_t    scheduler_outcomes_q[$];
    int unsigned mismatch_count;
    int unsigned cycles;
    logic        calm;

    elevator_request_scheduler #(
        .FLOORS(FLOORS)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tuser (i_s_tuser),
        .i_s_tdata (i_s_tdata),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // End the run if it hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Stall the receiver at random, except during the calm stretch.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_m_tready <= calm || ($urandom_range(99) >= 23);
        end
    end

    // Request bits of every floor beyond f in the given direction.
    function automatic logic [PEND_W-1:0] reach_mask(int unsigned f, logic up);
        logic [15:0] below;
        logic [15:0] through;
        below   = (16'd1 << (3 * f)) - 16'd1;
        through = (16'd1 << (3 * (f + 1))) - 16'd1;
        return up ? ~through[PEND_W-1:0] : below[PEND_W-1:0];
    endfunction

    // Apply one event to the bench copy of the state and form its result.
    function automatic outcome_t predict_scheduler_event(logic [2:0] op, logic [3:0] fl,
                                                         logic [1:0] bt);
        outcome_t          res;
        logic [2:0]        here;
        logic [PEND_W-1:0] ahead;
        logic [PEND_W-1:0] behind;
        res = '0;
        case (op)
            OP_PRESS: begin
                if (fl < FLOORS && bt != BTN_NONE) begin
                    req_bits[3 * int'(fl) + int'(bt)] = 1'b1;
                end
            end
            OP_ARRIVE: begin
                if (fl < FLOORS) begin
                    at_floor    = fl;
                    floor_valid = 1'b1;
                    here        = req_bits[3 * int'(fl) +: 3];
                    ahead       = reach_mask(fl, heading_up);
                    // calls in the travel direction and cab calls always stop;
                    // an opposite call stops only with nothing further on
                    res.stop = here[heading_up ? BTN_HALL_UP : BTN_HALL_DOWN]
                            || here[BTN_CAB]
                            || ((req_bits & ahead) == '0
                                && here[heading_up ? BTN_HALL_DOWN : BTN_HALL_UP]);
                end else begin
                    floor_valid = 1'b0;
                end
            end
            OP_SERVE: begin
                if (floor_valid) begin
                    req_bits[3 * int'(at_floor) +: 3] = 3'b000;
                end
            end
            OP_CLEAR: begin
                req_bits = '0;
            end
            OP_CHOOSE: begin
                if (floor_valid) begin
                    ahead  = reach_mask(at_floor, heading_up);
                    behind = reach_mask(at_floor, !heading_up);
                    if ((req_bits & ahead) != '0) begin
                        parked = 1'b0;
                    end else if ((req_bits & behind) != '0) begin
                        parked     = 1'b0;
                        heading_up = !heading_up;
                    end else begin
                        parked = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        res.motor   = parked ? MOTOR_STOP : (heading_up ? MOTOR_UP : MOTOR_DOWN);
        res.pending = req_bits;
        return res;
    endfunction

    // Compare each returned result with the oldest prediction.
    always @(posedge i_clk) begin
        outcome_t got;
        outcome_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = outcome_t'(o_m_tdata);
            if (scheduler_outcomes_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: result with nothing expected: expected none, actual %h",
                             $realtime, o_m_tdata);
                end
            end else begin
                want = scheduler_outcomes_q.pop_front();
                if (got.stop !== want.stop) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: stop_here expected %b actual %b",
                                 $realtime, want.stop, got.stop);
                    end
                end
                if (got.motor !== want.motor) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: motor_direction expected %b actual %b",
                                 $realtime, want.motor, got.motor);
                    end
                end
                if (got.pending !== want.pending) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: pending_requests expected %h actual %h",
                                 $realtime, want.pending, got.pending);
                    end
                end
                if (got.pad !== want.pad) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: pad bit expected %b actual %b",
                                 $realtime, want.pad, got.pad);
                    end
                end
            end
        end
    end

    // Present one event, hold it until the transfer, then predict its result.
    task automatic issue_event(logic [2:0] op, logic [3:0] fl, logic [1:0] bt);
        int unsigned gap;
        gap = (!calm && $urandom_range(99) < 23) ? $urandom_range(4, 1) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tuser  <= op;
        i_s_tdata  <= {2'b00, bt, fl};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        scheduler_outcomes_q.push_back(predict_scheduler_event(op, fl, bt));
    endtask

    // Drop valid and hold off until every predicted result has come back.
    task automatic await_quiet();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (scheduler_outcomes_q.size() != 0) @(posedge i_clk);
    endtask

    // Floor unknown after reset: choose and serve must leave state alone.
    task automatic test_unknown_floor();
        issue_event(OP_CHOOSE, 4'd0, BTN_HALL_UP);
        issue_event(OP_SERVE, 4'd0, BTN_HALL_UP);
        issue_event(OP_PRESS, 4'd0, BTN_HALL_UP);
        issue_event(OP_SERVE, 4'd0, BTN_HALL_UP);
        await_quiet();
    endtask

    // Presses at the top floor, above it, and with no button.
    task automatic test_press_range();
        issue_event(OP_PRESS, 4'(FLOORS - 1), BTN_CAB);
        issue_event(OP_PRESS, 4'd15, BTN_CAB);
        issue_event(OP_PRESS, 4'd1, BTN_NONE);
        issue_event(OP_PRESS, 4'd2, BTN_HALL_DOWN);
        await_quiet();
    endtask

    // One sweep up and back: same-direction, cab, passing and opposite calls.
    task automatic test_stop_decisions();
        issue_event(OP_ARRIVE, 4'd0, BTN_HALL_UP);
        issue_event(OP_SERVE, 4'd0, BTN_HALL_UP);
        issue_event(OP_CHOOSE, 4'd0, BTN_HALL_UP);
        issue_event(OP_ARRIVE, 4'd1, BTN_HALL_UP);
        issue_event(OP_ARRIVE, 4'd2, BTN_HALL_UP);
        issue_event(OP_ARRIVE, 4'(FLOORS - 1), BTN_HALL_UP);
        issue_event(OP_SERVE, 4'd0, BTN_HALL_UP);
        issue_event(OP_CHOOSE, 4'd0, BTN_HALL_UP);
        issue_event(OP_ARRIVE, 4'd2, BTN_HALL_UP);
        issue_event(OP_PRESS, 4'd1, BTN_HALL_UP);
        issue_event(OP_ARRIVE, 4'd1, BTN_HALL_UP);
        issue_event(OP_SERVE, 4'd0, BTN_HALL_UP);
        issue_event(OP_CHOOSE, 4'd0, BTN_HALL_UP);
        await_quiet();
    endtask

    // Undefined operations, an arrival off the shaft, and clear all.
    task automatic test_undefined_and_clear();
        issue_event(OP_PRESS, 4'd3, BTN_HALL_DOWN);
        issue_event(OP_SPARE_A, 4'd15, BTN_NONE);
        issue_event(OP_SPARE_B, 4'd2, BTN_CAB);
        issue_event(OP_SPARE_C, 4'd0, BTN_HALL_UP);
        issue_event(OP_ARRIVE, 4'd12, BTN_CAB);
        issue_event(OP_CLEAR, 4'd0, BTN_HALL_UP);
        await_quiet();
    endtask

    // Random traffic: the cab mostly follows its motor command floor by floor
    // while calls arrive; a share of noise events is mixed in.
    task automatic test_random_traffic(int unsigned count);
        int unsigned done_items;
        int unsigned pick;
        int unsigned sub;
        logic [3:0]  fl;
        done_items = 0;
        while (done_items < count) begin
            calm = (done_items >= 300 && done_items < 600);
            if (done_items % 250 == 249) begin
                await_quiet();
            end
            pick = $urandom_range(99);
            if (pick < 34) begin
                issue_event(OP_PRESS, 4'($urandom_range(FLOORS - 1)),
                            2'($urandom_range(2)));
                done_items++;
            end else if (pick < 58) begin
                fl = 4'($urandom_range(FLOORS - 1));
                if (floor_valid && !parked && $urandom_range(4) != 0) begin
                    // step one floor along the motor command
                    if (heading_up && at_floor < FLOORS - 1) begin
                        fl = at_floor + 4'd1;
                    end else if (!heading_up && at_floor > 0) begin
                        fl = at_floor - 4'd1;
                    end
                end
                issue_event(OP_ARRIVE, fl, 2'($urandom_range(3)));
                done_items++;
            end else if (pick < 70) begin
                issue_event(OP_SERVE, 4'($urandom_range(15)), 2'($urandom_range(3)));
                done_items++;
            end else if (pick < 88) begin
                issue_event(OP_CHOOSE, 4'($urandom_range(15)), 2'($urandom_range(3)));
                done_items++;
            end else if (pick < 91) begin
                issue_event(OP_CLEAR, 4'($urandom_range(15)), 2'($urandom_range(3)));
                done_items++;
            end else begin
                sub = $urandom_range(3);
                case (sub)
                    0: begin
                        issue_event(OP_PRESS, 4'($urandom_range(15, FLOORS)),
                                    2'($urandom_range(3)));
                    end
                    1: begin
                        issue_event(OP_PRESS, 4'($urandom_range(FLOORS - 1)), BTN_NONE);
                    end
                    2: begin
                        issue_event(OP_ARRIVE, 4'($urandom_range(15, FLOORS)),
                                    2'($urandom_range(3)));
                    end
                    default: begin
                        issue_event(3'($urandom_range(OP_SPARE_C, OP_SPARE_A)),
                                    4'($urandom_range(15)), 2'($urandom_range(3)));
                    end
                endcase
                done_items++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_s_tuser      = OP_PRESS;
        i_s_tdata      = '0;
        i_s_tvalid     = 1'b0;
        i_m_tready     = 1'b0;
        calm           = 1'b0;
        cycles         = 0;
        mismatch_count = 0;
        req_bits       = '0;
        at_floor       = '0;
        floor_valid    = 1'b0;
        heading_up     = 1'b1;
        parked         = 1'b1;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_unknown_floor();
        test_press_range();
        test_stop_decisions();
        test_undefined_and_clear();
        test_random_traffic(1600);

        await_quiet();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
